// ===== rtl/lsop_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsop_pkg: shared types and codes for the list set operations core
// Element, probe and cell control types; input kind and list id codes.
// ----------------------------------------------------------------------------
package lsop_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;

    // one stored list element and its membership flag
    typedef struct packed {
        data_t value;
        logic  flag;
    } entry_t;

    // token that walks the cell row during the membership pass
    typedef struct packed {
        data_t value;
        logic  valid;
        logic  found;
    } probe_t;

    typedef struct packed {
        logic rot_a;
        logic rot_b;
        logic clr_fb;
    } cell_ctl_t;

    localparam logic [1:0] KIND_A   = 2'd0;
    localparam logic [1:0] KIND_B   = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;

    localparam logic [1:0] LIST_INTER = 2'd0;
    localparam logic [1:0] LIST_UNION = 2'd1;
    localparam logic [1:0] LIST_DIFF  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/list_set_operations_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// list_set_operations_core: intersection, union and difference of two lists
// Loads lists A and B into a row of cells, then emits A and B, A or B,
// and A minus B as three tagged result lists.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_kind, s_value
//   m_       out  m_valid/m_ready    m_list_id, m_value_res, m_list_empty,
//                                    m_last_of_list, m_last_of_run, m_overflow
//
// A compute beat first probes (A values walk the cell row past B), then
// counts B, then emits the result lists plus one marker beat per empty
// list; emission stalls while m_ready is low and a result beat is held.
// s_ready is high only between runs. Reset is synchronous and clears
// counts and flags.
// ----------------------------------------------------------------------------
module list_set_operations_core
    import lsop_pkg::*;
#(
    parameter int MAX_ELEMS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_list_id,
    output logic signed [31:0]      m_value_res,
    output logic                    m_list_empty,
    output logic                    m_last_of_list,
    output logic                    m_last_of_run,
    output logic                    m_overflow
);

    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int SW = $clog2(2 * MAX_ELEMS);
    localparam int LW = $clog2(2 * MAX_ELEMS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COUNT,
        ST_EMIT,
        ST_MARK
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_a_reg, count_a_next;
    logic [CW-1:0]   count_b_reg, count_b_next;
    logic            dropped_reg, dropped_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [CW-1:0]   ni_reg, ni_next;
    logic [CW-1:0]   nb_reg, nb_next;
    logic [1:0]      lst_reg, lst_next;
    logic            part_b_reg, part_b_next;
    logic [LW-1:0]   ocnt_reg, ocnt_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_id_reg, out_id_next;
    data_t           out_value_reg, out_value_next;
    logic            out_empty_reg, out_empty_next;
    logic            out_last_list_reg, out_last_list_next;
    logic            out_last_run_reg, out_last_run_next;
    logic            out_ovf_reg, out_ovf_next;

    cell_ctl_t       ctl;
    logic            load_a, load_b;
    logic            issue_valid;
    logic            fa_sel, fa_new;
    logic            slot_free;
    logic            cap;
    logic            skip_diff;
    logic            run_last_list;
    logic            ovf;
    logic [LW-1:0]   len;
    entry_t          head;
    logic            in_range;
    logic            want;
    logic            advance;
    logic            last_step;
    logic            s_fire;

    entry_t          a_out     [MAX_ELEMS];
    entry_t          b_out     [MAX_ELEMS];
    entry_t          a_in      [MAX_ELEMS];
    entry_t          b_in      [MAX_ELEMS];
    probe_t          probe_in  [MAX_ELEMS];
    probe_t          probe_out [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] wr_a, wr_b, b_valid;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_a    = s_fire && (s_kind == KIND_A) && (count_a_reg < CW'(MAX_ELEMS));
    assign load_b    = s_fire && (s_kind == KIND_B) && (count_b_reg < CW'(MAX_ELEMS));
    assign slot_free = !out_valid_reg || m_ready;

    // probe phase: first half issues A values, second half writes back flags
    assign issue_valid = (state_reg == ST_PROBE) && (step_reg < SW'(MAX_ELEMS))
                         && (step_reg < SW'(count_a_reg));
    assign fa_sel      = (state_reg == ST_PROBE) && (step_reg >= SW'(MAX_ELEMS));
    assign fa_new      = probe_out[MAX_ELEMS-1].valid && probe_out[MAX_ELEMS-1].found;

    // a full run with disjoint full lists loses its final difference beat
    assign cap = (count_a_reg == CW'(MAX_ELEMS)) && (count_b_reg == CW'(MAX_ELEMS))
                 && (ni_reg == '0);
    assign ovf = dropped_reg || cap;

    // single-element lists: the cap removes the whole difference list
    assign skip_diff     = cap && (count_a_reg == CW'(1));
    assign run_last_list = (lst_reg == LIST_DIFF) || ((lst_reg == LIST_UNION) && skip_diff);

    always_comb begin
        case (lst_reg)
            LIST_INTER: len = LW'(ni_reg);
            LIST_UNION: len = LW'(count_a_reg) + LW'(nb_reg);
            LIST_DIFF:  len = cap ? (LW'(count_a_reg) - LW'(1))
                                  : (LW'(count_a_reg) - LW'(ni_reg));
            default:    len = '0;
        endcase
    end

    assign head     = part_b_reg ? b_out[0] : a_out[0];
    assign in_range = step_reg < (part_b_reg ? SW'(count_b_reg) : SW'(count_a_reg));

    always_comb begin
        want = 1'b0;
        case (lst_reg)
            LIST_INTER: want = head.flag;
            LIST_UNION: want = part_b_reg ? !head.flag : 1'b1;
            LIST_DIFF:  want = !head.flag;
            default:    want = 1'b0;
        endcase
        want = want && in_range && (ocnt_reg < len);
    end

    assign advance   = !want || slot_free;
    assign last_step = (step_reg == SW'(MAX_ELEMS - 1));

    always_comb begin
        ctl.rot_a  = (state_reg == ST_PROBE)
                     || ((state_reg == ST_EMIT) && !part_b_reg && advance);
        ctl.rot_b  = ((state_reg == ST_COUNT))
                     || ((state_reg == ST_EMIT) && part_b_reg && advance);
        ctl.clr_fb = s_fire && (s_kind == KIND_RUN);
    end

    genvar k;
    generate
        for (k = 0; k < MAX_ELEMS; k++) begin : g_cell
            assign wr_a[k]    = load_a && (count_a_reg == CW'(k));
            assign wr_b[k]    = load_b && (count_b_reg == CW'(k));
            assign b_valid[k] = CW'(k) < count_b_reg;

            if (k == MAX_ELEMS - 1) begin : g_tail
                assign a_in[k] = {a_out[0].value, fa_sel ? fa_new : a_out[0].flag};
                assign b_in[k] = b_out[0];
            end else begin : g_mid
                assign a_in[k] = a_out[k+1];
                assign b_in[k] = b_out[k+1];
            end

            if (k == 0) begin : g_head
                assign probe_in[k] = {a_out[0].value, issue_valid, 1'b0};
            end else begin : g_body
                assign probe_in[k] = probe_out[k-1];
            end

            lsop_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .wr_a      (wr_a[k]),
                .wr_b      (wr_b[k]),
                .ld_value  (s_value),
                .b_valid   (b_valid[k]),
                .a_in      (a_in[k]),
                .b_in      (b_in[k]),
                .probe_in  (probe_in[k]),
                .a_out     (a_out[k]),
                .b_out     (b_out[k]),
                .probe_out (probe_out[k])
            );
        end
    endgenerate

    always_comb begin
        state_next         = state_reg;
        count_a_next       = count_a_reg;
        count_b_next       = count_b_reg;
        dropped_next       = dropped_reg;
        step_next          = step_reg;
        ni_next            = ni_reg;
        nb_next            = nb_reg;
        lst_next           = lst_reg;
        part_b_next        = part_b_reg;
        ocnt_next          = ocnt_reg;
        out_valid_next     = out_valid_reg && !m_ready;
        out_id_next        = out_id_reg;
        out_value_next     = out_value_reg;
        out_empty_next     = out_empty_reg;
        out_last_list_next = out_last_list_reg;
        out_last_run_next  = out_last_run_reg;
        out_ovf_next       = out_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_kind)
                        KIND_A: begin
                            if (load_a) begin
                                count_a_next = count_a_reg + CW'(1);
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        KIND_B: begin
                            if (load_b) begin
                                count_b_next = count_b_reg + CW'(1);
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        KIND_RUN: begin
                            state_next = ST_PROBE;
                            step_next  = '0;
                            ni_next    = '0;
                            nb_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (fa_sel && fa_new) begin
                    ni_next = ni_reg + CW'(1);
                end
                if (step_reg == SW'(2 * MAX_ELEMS - 1)) begin
                    state_next = ST_COUNT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_COUNT: begin
                if ((step_reg < SW'(count_b_reg)) && !b_out[0].flag) begin
                    nb_next = nb_reg + CW'(1);
                end
                if (last_step) begin
                    state_next  = ST_EMIT;
                    step_next   = '0;
                    lst_next    = LIST_INTER;
                    part_b_next = 1'b0;
                    ocnt_next   = '0;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_EMIT: begin
                if (want && slot_free) begin
                    out_valid_next     = 1'b1;
                    out_id_next        = lst_reg;
                    out_value_next     = head.value;
                    out_empty_next     = 1'b0;
                    out_last_list_next = (ocnt_reg + LW'(1)) == len;
                    out_last_run_next  = ((ocnt_reg + LW'(1)) == len) && run_last_list;
                    out_ovf_next       = ovf;
                    ocnt_next          = ocnt_reg + LW'(1);
                end
                if (advance) begin
                    step_next = step_reg + SW'(1);
                    if (last_step) begin
                        step_next = '0;
                        if ((lst_reg == LIST_UNION) && !part_b_reg) begin
                            part_b_next = 1'b1;
                        end else if (len == '0) begin
                            state_next = ST_MARK;
                        end else if (run_last_list) begin
                            state_next   = ST_IDLE;
                            count_a_next = '0;
                            count_b_next = '0;
                            dropped_next = 1'b0;
                        end else begin
                            lst_next    = lst_reg + 2'd1;
                            part_b_next = 1'b0;
                            ocnt_next   = '0;
                        end
                    end
                end
            end
            ST_MARK: begin
                if (slot_free) begin
                    out_valid_next     = 1'b1;
                    out_id_next        = lst_reg;
                    out_value_next     = '0;
                    out_empty_next     = 1'b1;
                    out_last_list_next = 1'b1;
                    out_last_run_next  = (lst_reg == LIST_DIFF);
                    out_ovf_next       = ovf;
                    if (lst_reg == LIST_DIFF) begin
                        state_next   = ST_IDLE;
                        count_a_next = '0;
                        count_b_next = '0;
                        dropped_next = 1'b0;
                    end else begin
                        state_next  = ST_EMIT;
                        lst_next    = lst_reg + 2'd1;
                        part_b_next = 1'b0;
                        step_next   = '0;
                        ocnt_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            dropped_reg   <= 1'b0;
            step_reg      <= '0;
            ni_reg        <= '0;
            nb_reg        <= '0;
            lst_reg       <= LIST_INTER;
            part_b_reg    <= 1'b0;
            ocnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            dropped_reg   <= dropped_next;
            step_reg      <= step_next;
            ni_reg        <= ni_next;
            nb_reg        <= nb_next;
            lst_reg       <= lst_next;
            part_b_reg    <= part_b_next;
            ocnt_reg      <= ocnt_next;
            out_valid_reg <= out_valid_next;
        end
        out_id_reg        <= out_id_next;
        out_value_reg     <= out_value_next;
        out_empty_reg     <= out_empty_next;
        out_last_list_reg <= out_last_list_next;
        out_last_run_reg  <= out_last_run_next;
        out_ovf_reg       <= out_ovf_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_list_id      = out_id_reg;
    assign m_value_res    = out_value_reg;
    assign m_list_empty   = out_empty_reg;
    assign m_last_of_list = out_last_list_reg;
    assign m_last_of_run  = out_last_run_reg;
    assign m_overflow     = out_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a_reg <= CW'(MAX_ELEMS)) && (count_b_reg <= CW'(MAX_ELEMS)))
        else $error("list count above capacity");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (ocnt_reg <= len))
        else $error("more beats emitted than list length");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_list_empty) |-> (m_last_of_list && (m_value_res == '0)))
        else $error("empty marker not a lone zero beat");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_run) |->
        (m_last_of_list && ((m_list_id == LIST_DIFF) || m_overflow)))
        else $error("run end outside difference list");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_kind == KIND_RUN)) |=> (state_reg == ST_PROBE) && !s_ready)
        else $error("compute beat did not start probe pass");

endmodule
`default_nettype wire

// ===== rtl/lsop_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsop_cell: one cell of the list row
// Holds one A entry and one B entry, both rotating toward the head, and one
// probe stage that compares the passing A value against the local B entry.
// ----------------------------------------------------------------------------
module lsop_cell
    import lsop_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ctl_t ctl,
    input  wire logic      wr_a,
    input  wire logic      wr_b,
    input  wire data_t     ld_value,
    input  wire logic      b_valid,
    input  wire entry_t    a_in,
    input  wire entry_t    b_in,
    input  wire probe_t    probe_in,
    output entry_t         a_out,
    output entry_t         b_out,
    output probe_t         probe_out
);

    entry_t a_reg;
    entry_t b_reg;
    probe_t probe_reg;
    logic   hit;

    assign hit = probe_in.valid && b_valid && (probe_in.value == b_reg.value);

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            a_reg <= {ld_value, 1'b0};
        end else if (ctl.rot_a) begin
            a_reg <= a_in;
        end

        if (wr_b) begin
            b_reg <= {ld_value, 1'b0};
        end else if (ctl.rot_b) begin
            b_reg <= b_in;
        end else if (ctl.clr_fb) begin
            b_reg.flag <= 1'b0;
        end else if (hit) begin
            b_reg.flag <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
            probe_reg.found <= 1'b0;
        end else begin
            probe_reg.valid <= probe_in.valid;
            probe_reg.found <= probe_in.found | hit;
        end
        probe_reg.value <= probe_in.value;
    end

    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign probe_out = probe_reg;

endmodule
`default_nettype wire
